// ===== rtl/assert_macros.svh =====
// Assertion macros for the fractal value noise RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define FVN_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("fvn assertion failed");

// Check that cons holds in the cycle after ante
`define FVN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fvn assertion failed");

`endif

// ===== rtl/fvn_pkg.sv =====
// Constants, types and the blend function of the fractal value noise block
package fvn_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int MAX_OCTAVES_DEF = 8;
  localparam int COORD_W         = 32;
  localparam int NOISE_W         = 32;
  localparam int OCT_CNT_W       = 4;
  localparam logic [OCT_CNT_W-1:0] OCT_CNT_RST = 4'd4;

  localparam logic [31:0] KEY_MUL_Y  = 32'd57;
  localparam logic [31:0] KEY_MUL_Z  = 32'd113;
  localparam logic [31:0] HASH_MUL   = 32'd15731;
  localparam logic [31:0] HASH_ADD_A = 32'd789221;
  localparam logic [31:0] HASH_ADD_B = 32'd1376312589;
  localparam logic signed [31:0] LEVEL_ONE = 32'sd1073741824;

  localparam int DIV_SPS = 4;

  typedef logic [31:0] corner_off_t [8];
  localparam corner_off_t CORNER_OFF = '{32'd0, 32'd1, 32'd57, 32'd58,
                                         32'd113, 32'd114, 32'd170, 32'd171};

  function automatic logic signed [31:0] blend(input logic signed [31:0] a,
                                               input logic signed [31:0] b,
                                               input logic [FRAC_BITS-1:0] t);
    logic signed [32:0]            diff;
    logic signed [33+FRAC_BITS:0]  prod;
    logic signed [33+FRAC_BITS:0]  shr;
    diff = 33'(b) - 33'(a);
    prod = diff * $signed({1'b0, t});
    shr  = prod >>> FRAC_BITS;
    return a + shr[31:0];
  endfunction

endpackage

// ===== rtl/fractal_value_noise_3d.sv =====
// Fractal value noise in 3D: a point in Q16.16 gives fBm noise in Q1.30.
// Fully pipelined: one point may be started in every cycle (busy stays low) and each
// result appears on noise_value_o with done_o for one cycle. Each point passes in turn
// through the seven-stage octave lanes (hash multiplies and blends), the weighting
// adder tree and the divider by 2^n - 1, which resolves four quotient bits per stage.
// The receiver cannot stall. octave_count_i is written while no point is in flight (a
// rule for the user that the block does not enforce); 0 acts as 1 and values above
// MAX_OCTAVES act as MAX_OCTAVES.
module fractal_value_noise_3d #(
  parameter int MAX_OCTAVES = fvn_pkg::MAX_OCTAVES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [fvn_pkg::COORD_W-1:0]  coord_x_i,
  input  logic signed [fvn_pkg::COORD_W-1:0]  coord_y_i,
  input  logic signed [fvn_pkg::COORD_W-1:0]  coord_z_i,
  input  logic                                octave_count_we_i,
  input  logic [fvn_pkg::OCT_CNT_W-1:0]       octave_count_i,
  output logic                                done_o,
  output logic signed [fvn_pkg::NOISE_W-1:0]  noise_value_o
);
  import fvn_pkg::*;

  `include "assert_macros.svh"

  localparam int NW     = $clog2(MAX_OCTAVES + 1);
  localparam int ACC_W  = 32 + MAX_OCTAVES;
  localparam int LEVELS = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 0;
  localparam int LEAVES = 1 << LEVELS;
  localparam int DS     = (ACC_W + DIV_SPS - 1) / DIV_SPS;
  localparam int I_TERM = 8;
  localparam int I_ABS  = 9 + LEVELS;
  localparam int LAST   = I_ABS + DS + 1;

  logic [OCT_CNT_W-1:0] oct_cnt_q;
  logic                 accept;
  logic [NW-1:0]        n_d;
  logic                 pv_q [0:LAST];
  logic [NW-1:0]        pn_q [0:LAST];
  logic signed [COORD_W-1:0] cx_q, cy_q, cz_q;
  logic signed [31:0]   sample [MAX_OCTAVES];
  logic signed [ACC_W-1:0] tr_q [0:LEVELS][0:LEAVES-1];
  logic                 neg_q [0:DS];
  logic [ACC_W-1:0]     mag_q;
  logic [MAX_OCTAVES-1:0] den_q;
  logic [ACC_W-1:0]     quo;
  logic [ACC_W-1:0]     res;
  logic signed [NOISE_W-1:0] noise_q;

  assign accept = start && !busy;
  assign busy   = 1'b0;

  always_comb begin
    if (oct_cnt_q == '0) begin
      n_d = NW'(1);
    end else if (32'(oct_cnt_q) > MAX_OCTAVES) begin
      n_d = NW'(MAX_OCTAVES);
    end else begin
      n_d = NW'(oct_cnt_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oct_cnt_q <= OCT_CNT_RST;
    end else if (octave_count_we_i) begin
      oct_cnt_q <= octave_count_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= LAST; k++) begin
        pv_q[k] <= 1'b0;
      end
    end else begin
      pv_q[0] <= accept;
      for (int k = 1; k <= LAST; k++) begin
        pv_q[k] <= pv_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pn_q[0] <= n_d;
    for (int k = 1; k <= LAST; k++) begin
      pn_q[k] <= pn_q[k-1];
    end
    cx_q <= coord_x_i;
    cy_q <= coord_y_i;
    cz_q <= coord_z_i;
  end

  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
    localparam logic [NW-1:0] IDX = NW'(i);
    fvn_octave #(
      .OCT(i)
    ) u_octave (
      .clk_i    (clk_i),
      .coord_x_i(cx_q),
      .coord_y_i(cy_q),
      .coord_z_i(cz_q),
      .sample_o (sample[i])
    );
    always_ff @(posedge clk_i) begin
      if (IDX < pn_q[I_TERM-1]) begin
        tr_q[0][i] <= ACC_W'(sample[i]) <<< (pn_q[I_TERM-1] - NW'(1) - IDX);
      end else begin
        tr_q[0][i] <= '0;
      end
    end
  end

  for (genvar i = MAX_OCTAVES; i < LEAVES; i++) begin : g_pad
    always_ff @(posedge clk_i) begin
      tr_q[0][i] <= '0;
    end
  end

  for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
    for (genvar j = 0; j < (LEAVES >> l); j++) begin : g_node
      always_ff @(posedge clk_i) begin
        tr_q[l][j] <= tr_q[l-1][2*j] + tr_q[l-1][2*j+1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q[0] <= tr_q[LEVELS][0][ACC_W-1];
    mag_q    <= tr_q[LEVELS][0][ACC_W-1] ? ACC_W'(-tr_q[LEVELS][0])
                                         : ACC_W'(tr_q[LEVELS][0]);
    den_q    <= MAX_OCTAVES'((64'd1 << pn_q[I_ABS-1]) - 64'd1);
    for (int k = 1; k <= DS; k++) begin
      neg_q[k] <= neg_q[k-1];
    end
    noise_q  <= res[NOISE_W-1:0];
  end

  fvn_div #(
    .W (ACC_W),
    .DW(MAX_OCTAVES)
  ) u_div (
    .clk_i(clk_i),
    .mag_i(mag_q),
    .den_i(den_q),
    .quo_o(quo)
  );

  assign res           = neg_q[DS] ? (~quo + ACC_W'(1)) : quo;
  assign done_o        = pv_q[LAST];
  assign noise_value_o = noise_q;

  `FVN_ASSERT(a_latency, accept |-> ##(LAST+1) done_o)
  `FVN_ASSERT(a_no_phantom, !accept |-> ##(LAST+1) !done_o)
  `FVN_ASSERT(a_range, done_o |-> (noise_value_o >= -LEVEL_ONE && noise_value_o <= LEVEL_ONE))
  `FVN_ASSERT(a_oct_ok, pv_q[I_TERM] |-> (pn_q[I_TERM] != '0 && 32'(pn_q[I_TERM]) <= MAX_OCTAVES))
  `FVN_ASSERT_NEXT(a_cfg_write, octave_count_we_i, oct_cnt_q == $past(octave_count_i))

endmodule

// ===== rtl/fvn_octave.sv =====
// One octave lane: lattice key, eight corner hashes and trilinear blend
module fvn_octave #(
  parameter int OCT = 0
) (
  input  logic                              clk_i,
  input  logic signed [fvn_pkg::COORD_W-1:0] coord_x_i,
  input  logic signed [fvn_pkg::COORD_W-1:0] coord_y_i,
  input  logic signed [fvn_pkg::COORD_W-1:0] coord_z_i,
  output logic signed [31:0]                sample_o
);
  import fvn_pkg::*;

  logic [63:0] sx, sy, sz;
  logic [31:0] key_q;
  logic [FRAC_BITS-1:0] fr_q [1:4][3];
  logic [FRAC_BITS-1:0] fy5_q, fz5_q, fz6_q;
  logic [31:0] k_d [8];
  logic [31:0] k_q [8];
  logic [31:0] kk_q [8];
  logic [31:0] k3_q [8];
  logic [31:0] p_q [8];
  logic [31:0] m_d [8];
  logic signed [31:0] lvl_q [8];
  logic signed [31:0] e_q [4];
  logic signed [31:0] f_q [2];
  logic signed [31:0] s_q;

  assign sx = {{32{coord_x_i[31]}}, coord_x_i} << OCT;
  assign sy = {{32{coord_y_i[31]}}, coord_y_i} << OCT;
  assign sz = {{32{coord_z_i[31]}}, coord_z_i} << OCT;

  always_comb begin
    for (int c = 0; c < 8; c++) begin
      k_d[c] = ((key_q + CORNER_OFF[c]) << 13) ^ (key_q + CORNER_OFF[c]);
      m_d[c] = k3_q[c] * p_q[c] + HASH_ADD_B;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= sx[FRAC_BITS+31:FRAC_BITS] + sy[FRAC_BITS+31:FRAC_BITS] * KEY_MUL_Y
              + sz[FRAC_BITS+31:FRAC_BITS] * KEY_MUL_Z;
    fr_q[1][0] <= sx[FRAC_BITS-1:0];
    fr_q[1][1] <= sy[FRAC_BITS-1:0];
    fr_q[1][2] <= sz[FRAC_BITS-1:0];
    for (int s = 2; s <= 4; s++) begin
      fr_q[s] <= fr_q[s-1];
    end
    for (int c = 0; c < 8; c++) begin
      k_q[c]   <= k_d[c];
      kk_q[c]  <= k_d[c] * k_d[c];
      k3_q[c]  <= k_q[c];
      p_q[c]   <= kk_q[c] * HASH_MUL + HASH_ADD_A;
      lvl_q[c] <= LEVEL_ONE - $signed({1'b0, m_d[c][30:0]});
    end
    for (int j = 0; j < 4; j++) begin
      e_q[j] <= blend(lvl_q[2*j], lvl_q[2*j+1], fr_q[4][0]);
    end
    fy5_q <= fr_q[4][1];
    fz5_q <= fr_q[4][2];
    for (int j = 0; j < 2; j++) begin
      f_q[j] <= blend(e_q[2*j], e_q[2*j+1], fy5_q);
    end
    fz6_q <= fz5_q;
    s_q   <= blend(f_q[0], f_q[1], fz6_q);
  end

  assign sample_o = s_q;

endmodule

// ===== rtl/fvn_div.sv =====
// Pipelined restoring divider, DIV_SPS quotient bits per stage
module fvn_div #(
  parameter int W  = 40,
  parameter int DW = 8
) (
  input  logic          clk_i,
  input  logic [W-1:0]  mag_i,
  input  logic [DW-1:0] den_i,
  output logic [W-1:0]  quo_o
);
  import fvn_pkg::*;

  localparam int DS = (W + DIV_SPS - 1) / DIV_SPS;
  localparam int RW = DW + 1;

  logic [RW-1:0] r_q [0:DS];
  logic [W-1:0]  w_q [0:DS];
  logic [DW-1:0] d_q [0:DS];

  assign r_q[0] = '0;
  assign w_q[0] = mag_i;
  assign d_q[0] = den_i;

  for (genvar s = 1; s <= DS; s++) begin : g_stage
    logic [RW-1:0] r_d;
    logic [W-1:0]  w_d;
    always_comb begin
      r_d = r_q[s-1];
      w_d = w_q[s-1];
      for (int t = 0; t < DIV_SPS; t++) begin
        if ((s - 1) * DIV_SPS + t < W) begin
          r_d = {r_d[RW-2:0], w_d[W-1]};
          w_d = w_d << 1;
          if (r_d >= {1'b0, d_q[s-1]}) begin
            r_d    = r_d - {1'b0, d_q[s-1]};
            w_d[0] = 1'b1;
          end
        end
      end
    end
    always_ff @(posedge clk_i) begin
      r_q[s] <= r_d;
      w_q[s] <= w_d;
      d_q[s] <= d_q[s-1];
    end
  end

  assign quo_o = w_q[DS];

endmodule
